### rtl/core/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg: shared types and constants of the character lcd write sequencer
// holds request codes, register indexes, lcd command bytes and the
// command and status bundles between controller and datapath
// ----------------------------------------------------------------------------
package clcd_pkg;

    // request kinds carried in s_tuser
    localparam logic [2:0] FUNC_INIT = 3'd0;
    localparam logic [2:0] FUNC_CMD  = 3'd1;
    localparam logic [2:0] FUNC_DATA = 3'd2;
    localparam logic [2:0] FUNC_POS  = 3'd3;
    localparam logic [2:0] FUNC_NUM  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_FOUR_BIT  = 2'd0;
    localparam logic [1:0] CFG_CURSOR_ON = 2'd1;
    localparam logic [1:0] CFG_BLINK_ON  = 2'd2;
    localparam logic [1:0] CFG_FOUR_ROWS = 2'd3;

    // lcd instruction bytes
    localparam logic [7:0] LCD_FSET_8BIT  = 8'h38;
    localparam logic [7:0] LCD_FSET_4BIT  = 8'h22;
    localparam logic [7:0] LCD_NIBBLE_PAD = 8'h0F;
    localparam logic [7:0] LCD_DISP_CTRL  = 8'h0C;
    localparam logic [7:0] LCD_CLEAR      = 8'h01;
    localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;

    // ddram row base addresses, with the set-address bit
    localparam logic [7:0] ROW0_BASE = 8'h80;
    localparam logic [7:0] ROW1_BASE = 8'hC0;
    localparam logic [7:0] ROW2_BASE = 8'h94;
    localparam logic [7:0] ROW3_BASE = 8'hD4;

    // ascii characters for decimal output
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    // sizes
    localparam int MAX_COLUMNS = 40;
    localparam int COL_W       = 6;
    localparam int NUM_W       = 16;
    localparam int BCD_DIGITS  = 5;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int QUEUE_DEPTH = 6;
    localparam int QLEN_W      = 3;
    localparam int STEP_W      = $clog2(NUM_W);

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic bcd_step;
        logic build;
        logic emit;
    } clcd_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [2:0] func;
        logic       out_free;
        logic       last_piece;
    } clcd_status_t;

    // row base address lookup
    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        unique case (row)
            2'd0: base = ROW0_BASE;
            2'd1: base = ROW1_BASE;
            2'd2: base = ROW2_BASE;
            2'd3: base = ROW3_BASE;
        endcase
        return base;
    endfunction

endpackage

### rtl/core/character_lcd_write_sequencer.sv
// ----------------------------------------------------------------------------
// character_lcd_write_sequencer: character lcd write sequencer top level
// turns lcd requests into enable strobes for a 4-bit or 8-bit bus
// ----------------------------------------------------------------------------
// One request is taken at a time. A request goes through capture, decode
// and queue build, then results go out one per cycle while the output is
// free: one per byte on the 8-bit bus, two per byte on the 4-bit bus but one
// for the padding byte of initialisation. A decimal number first adds binary
// to bcd shifting of the whole number, one bit per cycle, before its
// characters go out; the longest request is -32768 on the 4-bit bus. Unknown
// request kinds give no result after decode. The result register lets a
// finished strobe wait while the next request is already accepted.
module character_lcd_write_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[7:0], row[9:8], column[15:10], number[31:16]
    input  logic [2:0]  s_tuser,   // func[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // bus_data[7:0]
    output logic [1:0]  m_tuser,   // register_select[0], strobe_res[1]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [0:0]  cfg_wdata
);

    clcd_pkg::clcd_cmd_t    cmd;
    clcd_pkg::clcd_status_t status;

    // controller
    clcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    clcd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

### rtl/core/clcd_ctrl.sv
// ----------------------------------------------------------------------------
// clcd_ctrl: request sequencing controller
// steps each request through capture, decimal conversion, queue build and
// strobe emission, driving the datapath by command bundle
// ----------------------------------------------------------------------------
module clcd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  clcd_pkg::clcd_status_t status,
    output clcd_pkg::clcd_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_CONV,
        S_BUILD,
        S_EMIT
    } state_t;

    state_t                        state_reg, state_next;
    logic [clcd_pkg::STEP_W-1:0]   step_reg, step_next;

    // command decode from current state
    always_comb
    begin
        cmd          = '0;
        s_tready     = (state_reg == S_IDLE);
        cmd.capture  = (state_reg == S_IDLE) && s_tvalid;
        cmd.bcd_step = (state_reg == S_CONV);
        cmd.build    = (state_reg == S_BUILD);
        cmd.emit     = (state_reg == S_EMIT) && status.out_free;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                step_next = '0;
                unique case (status.func) inside
                    clcd_pkg::FUNC_INIT, clcd_pkg::FUNC_CMD,
                    clcd_pkg::FUNC_DATA, clcd_pkg::FUNC_POS:
                        state_next = S_BUILD;
                    clcd_pkg::FUNC_NUM:
                        state_next = S_CONV;
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_CONV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == clcd_pkg::STEP_W'(clcd_pkg::NUM_W - 1))
                    state_next = S_BUILD;
            end
            S_BUILD:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free && status.last_piece)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

### rtl/core/clcd_dp.sv
// ----------------------------------------------------------------------------
// clcd_dp: sequencer datapath
// holds configuration, the captured request, the binary to bcd shifter,
// the byte queue and the output register
// ----------------------------------------------------------------------------
module clcd_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [31:0]           s_tdata,
    input  logic [2:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_addr,
    input  logic [0:0]            cfg_wdata,
    input  clcd_pkg::clcd_cmd_t   cmd,
    output clcd_pkg::clcd_status_t status
);

    // configuration
    logic four_bit_reg, cursor_reg, blink_reg, four_rows_reg;

    // captured request
    logic [2:0]                   func_reg;
    logic [7:0]                   value_reg;
    logic [1:0]                   row_reg;
    logic [clcd_pkg::COL_W-1:0]   column_reg;
    logic                         neg_reg;

    // binary to bcd shifter
    logic [clcd_pkg::NUM_W-1:0]   bin_reg;
    logic [clcd_pkg::BCD_W-1:0]   bcd_reg;
    logic [clcd_pkg::BCD_W-1:0]   bcd_adj;

    // byte queue
    logic [7:0]                   q_byte_reg [clcd_pkg::QUEUE_DEPTH];
    logic [clcd_pkg::QUEUE_DEPTH-1:0] q_single_reg;
    logic [clcd_pkg::QLEN_W-1:0]  q_len_reg;
    logic                         phase_reg;
    logic                         rs_reg;
    logic                         rej_reg;

    // build values
    logic [7:0]                   b_byte [clcd_pkg::QUEUE_DEPTH];
    logic [clcd_pkg::QUEUE_DEPTH-1:0] b_single;
    logic [clcd_pkg::QLEN_W-1:0]  b_len;
    logic                         b_rs;
    logic                         b_rej;

    logic [3:0]                   dig [clcd_pkg::BCD_DIGITS];
    logic [2:0]                   lead;
    logic                         seen;
    logic [3:0]                   src;
    logic [7:0]                   disp_ctrl;
    logic [clcd_pkg::COL_W-1:0]   col_sat;
    logic [7:0]                   pos_addr;

    // output register
    logic                         m_tvalid_reg;
    logic [7:0]                   m_data_reg;
    logic                         m_rs_reg;
    logic                         m_strobe_reg;
    logic                         m_last_reg;

    // current piece
    logic                         entry_done;
    logic                         last_piece;
    logic [7:0]                   piece_data;

    // magnitude of the incoming number
    logic [clcd_pkg::NUM_W-1:0]   in_num;
    logic [clcd_pkg::NUM_W-1:0]   in_mag;

    assign in_num = s_tdata[31:16];
    assign in_mag = in_num[clcd_pkg::NUM_W-1] ? (~in_num + 1'b1) : in_num;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_bit_reg  <= 1'b0;
            cursor_reg    <= 1'b0;
            blink_reg     <= 1'b0;
            four_rows_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                clcd_pkg::CFG_FOUR_BIT:  four_bit_reg  <= cfg_wdata[0];
                clcd_pkg::CFG_CURSOR_ON: cursor_reg    <= cfg_wdata[0];
                clcd_pkg::CFG_BLINK_ON:  blink_reg     <= cfg_wdata[0];
                clcd_pkg::CFG_FOUR_ROWS: four_rows_reg <= cfg_wdata[0];
            endcase
        end
    end

    // add-3 correction of each bcd digit
    always_comb
    begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < clcd_pkg::BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
        end
    end

    // request capture and bcd shifting
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg   <= s_tuser;
            value_reg  <= s_tdata[7:0];
            row_reg    <= s_tdata[9:8];
            column_reg <= s_tdata[15:10];
            neg_reg    <= in_num[clcd_pkg::NUM_W-1];
            bin_reg    <= in_mag;
            bcd_reg    <= '0;
        end
        else if (cmd.bcd_step)
        begin
            bcd_reg <= {bcd_adj[clcd_pkg::BCD_W-2:0], bin_reg[clcd_pkg::NUM_W-1]};
            bin_reg <= {bin_reg[clcd_pkg::NUM_W-2:0], 1'b0};
        end
    end

    // digits most significant first, leading zero count
    always_comb
    begin
        for (int k = 0; k < clcd_pkg::BCD_DIGITS; k++)
            dig[k] = bcd_reg[4*(clcd_pkg::BCD_DIGITS-1-k) +: 4];
        lead = '0;
        seen = 1'b0;
        for (int k = 0; k < clcd_pkg::BCD_DIGITS - 1; k++)
        begin
            if (!seen && dig[k] == 4'd0)
                lead = lead + 3'd1;
            else
                seen = 1'b1;
        end
    end

    assign disp_ctrl = clcd_pkg::LCD_DISP_CTRL | {6'b0, cursor_reg, blink_reg};
    assign col_sat   = (column_reg >= clcd_pkg::COL_W'(clcd_pkg::MAX_COLUMNS))
                       ? clcd_pkg::COL_W'(clcd_pkg::MAX_COLUMNS - 1) : column_reg;
    assign pos_addr  = clcd_pkg::row_base(row_reg) + {2'b0, col_sat};

    // queue contents for the captured request
    always_comb
    begin
        for (int j = 0; j < clcd_pkg::QUEUE_DEPTH; j++)
            b_byte[j] = 8'h00;
        b_single = '0;
        b_len    = clcd_pkg::QLEN_W'(1);
        b_rs     = 1'b0;
        b_rej    = 1'b0;
        src      = '0;
        case (func_reg)
            clcd_pkg::FUNC_INIT:
            begin
                if (four_bit_reg)
                begin
                    b_byte[0]   = clcd_pkg::LCD_FSET_4BIT;
                    b_byte[1]   = clcd_pkg::LCD_NIBBLE_PAD;
                    b_single[1] = 1'b1;
                    b_byte[2]   = disp_ctrl;
                    b_byte[3]   = clcd_pkg::LCD_CLEAR;
                    b_byte[4]   = clcd_pkg::LCD_ENTRY_MODE;
                    b_len       = clcd_pkg::QLEN_W'(5);
                end
                else
                begin
                    b_byte[0] = clcd_pkg::LCD_FSET_8BIT;
                    b_byte[1] = disp_ctrl;
                    b_byte[2] = clcd_pkg::LCD_CLEAR;
                    b_byte[3] = clcd_pkg::LCD_ENTRY_MODE;
                    b_len     = clcd_pkg::QLEN_W'(4);
                end
            end
            clcd_pkg::FUNC_CMD:
            begin
                b_byte[0] = value_reg;
            end
            clcd_pkg::FUNC_DATA:
            begin
                b_byte[0] = value_reg;
                b_rs      = 1'b1;
            end
            clcd_pkg::FUNC_POS:
            begin
                if (row_reg[1] && !four_rows_reg)
                    b_rej = 1'b1;
                else
                    b_byte[0] = pos_addr;
            end
            default:
            begin
                // decimal number: optional minus then significant digits
                b_rs  = 1'b1;
                b_len = clcd_pkg::QLEN_W'(clcd_pkg::BCD_DIGITS) - lead + {2'b0, neg_reg};
                for (int j = 0; j < clcd_pkg::QUEUE_DEPTH; j++)
                begin
                    src = 4'(j) + {1'b0, lead} - {3'b0, neg_reg};
                    if (neg_reg && j == 0)
                        b_byte[j] = clcd_pkg::ASCII_MINUS;
                    else if (src < 4'(clcd_pkg::BCD_DIGITS))
                        b_byte[j] = clcd_pkg::ASCII_ZERO | {4'b0, dig[src[2:0]]};
                    else
                        b_byte[j] = clcd_pkg::ASCII_ZERO;
                end
            end
        endcase
    end

    // piece selection from the queue head
    assign entry_done = rej_reg || !four_bit_reg || q_single_reg[0] || phase_reg;
    assign last_piece = entry_done && (q_len_reg == clcd_pkg::QLEN_W'(1));

    always_comb
    begin
        if (rej_reg)
            piece_data = 8'h00;
        else if (!four_bit_reg)
            piece_data = q_byte_reg[0];
        else if (q_single_reg[0] || phase_reg)
            piece_data = {4'h0, q_byte_reg[0][3:0]};
        else
            piece_data = {4'h0, q_byte_reg[0][7:4]};
    end

    // queue load and shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_len_reg <= '0;
            phase_reg <= 1'b0;
        end
        else if (cmd.build)
        begin
            q_len_reg <= b_len;
            phase_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            if (entry_done)
            begin
                q_len_reg <= q_len_reg - 1'b1;
                phase_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.build)
        begin
            for (int j = 0; j < clcd_pkg::QUEUE_DEPTH; j++)
                q_byte_reg[j] <= b_byte[j];
            q_single_reg <= b_single;
            rs_reg       <= b_rs;
            rej_reg      <= b_rej;
        end
        else if (cmd.emit && entry_done)
        begin
            for (int j = 0; j < clcd_pkg::QUEUE_DEPTH - 1; j++)
                q_byte_reg[j] <= q_byte_reg[j+1];
            q_single_reg <= {1'b0, q_single_reg[clcd_pkg::QUEUE_DEPTH-1:1]};
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.emit)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            m_data_reg   <= piece_data;
            m_rs_reg     <= rs_reg && !rej_reg;
            m_strobe_reg <= !rej_reg;
            m_last_reg   <= last_piece;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {m_strobe_reg, m_rs_reg};
    assign m_tlast  = m_last_reg;

    // status back to the controller
    assign status.func       = func_reg;
    assign status.out_free   = !m_tvalid_reg || m_tready;
    assign status.last_piece = last_piece;

endmodule

### rtl/core/clcd_checker.sv
// ----------------------------------------------------------------------------
// clcd_checker: port level checks of the lcd write sequencer
// watches the stream ports for ordering and hold rules of the block
// ----------------------------------------------------------------------------
module clcd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // a rejected request gives a single blank result
    a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> m_tlast && (m_tdata == 8'h00) && !m_tuser[0])
        else $error("rejected result malformed");

    // one request at a time
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken during a request");

    // no new request while a run is unfinished
    a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request accepted mid run");

    // the next strobe of a run follows at once
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a run");

endmodule

bind character_lcd_write_sequencer clcd_checker u_clcd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
